// ===== hdl/stepper_move_sequencer_assert.svh =====
// assertion macros shared by the stepper move sequencer rtl
`ifndef STEPPER_MOVE_SEQUENCER_ASSERT_SVH
`define STEPPER_MOVE_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SMSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SMSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/smsq_pkg.sv =====
// shared types and constants of the stepper move sequencer
package smsq_pkg;

  // beat field widths
  localparam int AMOUNT_W = 16;
  localparam int SCALE_W  = 24;
  localparam int SETTLE_W = 16;
  localparam int PULSE_W  = 8;
  localparam int TOTAL_W  = 16;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_DATA_W = 24;

  // command codes carried in s_axis_tuser
  localparam logic [1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [1:0] MODE_ROTATE   = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_SCALE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS      = 8'd4;

  // register reset values
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'h010000;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd100;
  localparam logic [PULSE_W-1:0]  PULSE_RST  = 8'd1;

  // result beat, lowest field last
  typedef struct packed {
    logic [1:0]         pad;
    logic [TOTAL_W-1:0] step_total;
    logic               rejected;
    logic               busy_res;
    logic               dir_right;
    logic               dir_left;
    logic               step_level;
    logic               driver_off;
  } result_t;

endpackage

// ===== hdl/smsq_scale.sv =====
// amount to step count: magnitude times fixed-point scale, rounded and saturated
module smsq_scale #(
  parameter int COUNT_BITS      = 16,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic signed [smsq_pkg::AMOUNT_W-1:0] amount_i,
  input  logic [smsq_pkg::SCALE_W-1:0]         scale_i,
  output logic                                 neg_o,
  output logic                                 nonzero_o,
  output logic [COUNT_BITS-1:0]                steps_o
);
  import smsq_pkg::*;

  localparam int PROD_W = AMOUNT_W + SCALE_W;
  localparam int RND_W  = PROD_W - SCALE_FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(64'd1 << (SCALE_FRAC_BITS - 1));
  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  logic [AMOUNT_W-1:0] mag;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   rounded;
  logic [RND_W-1:0]    shifted;
  logic [63:0]         wide;

  // magnitude, most negative value maps to its unsigned twin
  assign neg_o     = amount_i[AMOUNT_W-1];
  assign nonzero_o = |amount_i;
  assign mag       = neg_o ? (~amount_i + AMOUNT_W'(1)) : amount_i;

  // product stays below 2^39, so the rounding add cannot carry out
  assign prod    = PROD_W'(mag) * PROD_W'(scale_i);
  assign rounded = prod + HALF;
  assign shifted = rounded[PROD_W-1:SCALE_FRAC_BITS];
  assign wide    = 64'(shifted);

  // saturate to the largest count
  assign steps_o = (wide > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : wide[COUNT_BITS-1:0];

endmodule

// ===== hdl/stepper_move_sequencer.sv =====
// Stepper move sequencer: command and tick beats in, one status beat out per beat in.
// An accepted input beat is held in the input register, and its result beat in the result register.
// Throughput: one beat per cycle while m_axis is not stalled; one input register, the sequencer
// update and scale multiply in one stage, then the result register.
// Reset: async active low; phase idle, counters and directions zero, registers at
// their reset values, both stages empty.
`include "stepper_move_sequencer_assert.svh"

module stepper_move_sequencer #(
  parameter int COUNT_BITS      = 16,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [smsq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [smsq_pkg::SCALE_W-1:0]       cfg_data_i,
  // input beats
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [15:0] amount
  input  logic [smsq_pkg::AMOUNT_W-1:0]      s_axis_tdata,
  // tuser: [1:0] mode
  input  logic [1:0]                         s_axis_tuser,
  // result beats
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: [0] driver_off, [1] step_level, [2] dir_left, [3] dir_right,
  //        [4] busy_res, [5] rejected, [21:6] step_total, [23:22] zero
  output logic [smsq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import smsq_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETTLE_ON,
    PH_HIGH,
    PH_LOW,
    PH_SETTLE_OFF
  } phase_e;

  // configuration registers
  logic [SCALE_W-1:0]  straight_scale_q, rotate_scale_q;
  logic [SETTLE_W-1:0] settle_ticks_q;
  logic [PULSE_W-1:0]  high_ticks_q, low_ticks_q;

  // input stage
  logic                in_valid_q;
  logic [1:0]          in_mode_q;
  logic [AMOUNT_W-1:0] in_amount_q;

  // sequencer state
  phase_e              phase_q, phase_d;
  logic [COUNT_BITS-1:0] steps_left_q, steps_left_d;
  logic [COUNT_BITS-1:0] last_total_q, last_total_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic                dir_left_q, dir_left_d;
  logic                dir_right_q, dir_right_d;

  // result stage
  logic                out_valid_q;
  result_t             result_q, result_d;

  logic                adv;
  logic                rej;
  logic [SCALE_W-1:0]  scale_sel;
  logic                amt_neg, amt_nonzero;
  logic [COUNT_BITS-1:0] scaled_steps;
  logic [TICK_W-1:0]   len;
  logic [TICK_W-1:0]   tick_inc;

  // handshakes: stage two moves when the result register is free or drains
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

  // scale for the command in the input stage
  assign scale_sel = (in_mode_q == MODE_ROTATE) ? rotate_scale_q : straight_scale_q;

  smsq_scale #(
    .COUNT_BITS      (COUNT_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_scale (
    .amount_i  (in_amount_q),
    .scale_i   (scale_sel),
    .neg_o     (amt_neg),
    .nonzero_o (amt_nonzero),
    .steps_o   (scaled_steps)
  );

  // length of the running phase and the bumped tick count
  always_comb begin
    unique case (phase_q)
      PH_HIGH: len = TICK_W'(high_ticks_q);
      PH_LOW:  len = TICK_W'(low_ticks_q);
      default: len = settle_ticks_q;
    endcase
    tick_inc = tick_q + TICK_W'(1);
  end

  // sequencer update for the beat in the input stage
  always_comb begin
    phase_d      = phase_q;
    steps_left_d = steps_left_q;
    last_total_d = last_total_q;
    tick_d       = tick_q;
    dir_left_d   = dir_left_q;
    dir_right_d  = dir_right_q;
    rej          = 1'b0;
    unique case (in_mode_q)
      MODE_STRAIGHT, MODE_ROTATE: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          if (amt_nonzero) begin
            dir_left_d  = !amt_neg;
            dir_right_d = (in_mode_q == MODE_ROTATE) ? amt_neg : !amt_neg;
          end
          last_total_d = scaled_steps;
          steps_left_d = scaled_steps;
          tick_d       = '0;
          phase_d      = PH_SETTLE_ON;
        end
      end
      MODE_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (tick_inc < len) begin
            tick_d = tick_inc;
          end else begin
            tick_d = '0;
            unique case (phase_q)
              PH_SETTLE_ON, PH_LOW: begin
                if (steps_left_q != '0) begin
                  steps_left_d = steps_left_q - COUNT_BITS'(1);
                  phase_d      = PH_HIGH;
                end else begin
                  phase_d = PH_SETTLE_OFF;
                end
              end
              PH_HIGH: phase_d = PH_LOW;
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // result fields show the state after the beat
  always_comb begin
    result_d.pad        = '0;
    result_d.step_total = TOTAL_W'(last_total_d);
    result_d.rejected   = rej;
    result_d.busy_res   = (phase_d != PH_IDLE);
    result_d.dir_right  = dir_right_d;
    result_d.dir_left   = dir_left_d;
    result_d.step_level = (phase_d == PH_HIGH);
    result_d.driver_off = (phase_d == PH_IDLE);
  end

  // control state, configuration and stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      straight_scale_q <= SCALE_RST;
      rotate_scale_q   <= SCALE_RST;
      settle_ticks_q   <= SETTLE_RST;
      high_ticks_q     <= PULSE_RST;
      low_ticks_q      <= PULSE_RST;
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      phase_q          <= PH_IDLE;
      steps_left_q     <= '0;
      last_total_q     <= '0;
      tick_q           <= '0;
      dir_left_q       <= 1'b0;
      dir_right_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_STRAIGHT_SCALE: straight_scale_q <= cfg_data_i;
          REG_ROTATE_SCALE:   rotate_scale_q   <= cfg_data_i;
          REG_SETTLE_TICKS:   settle_ticks_q   <= cfg_data_i[SETTLE_W-1:0];
          REG_HIGH_TICKS:     high_ticks_q     <= cfg_data_i[PULSE_W-1:0];
          REG_LOW_TICKS:      low_ticks_q      <= cfg_data_i[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q  <= 1'b1;
        phase_q      <= phase_d;
        steps_left_q <= steps_left_d;
        last_total_q <= last_total_d;
        tick_q       <= tick_d;
        dir_left_q   <= dir_left_d;
        dir_right_q  <= dir_right_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q   <= s_axis_tuser;
      in_amount_q <= s_axis_tdata;
    end
    if (adv) begin
      result_q <= result_d;
    end
  end

  // checks on the sequencer and the stage flow
  `SMSQ_ASSERT_NEXT(a_busy_cmd_no_change,
    adv && (in_mode_q == MODE_STRAIGHT || in_mode_q == MODE_ROTATE) && phase_q != PH_IDLE,
    $stable(phase_q) && $stable(steps_left_q) && $stable(last_total_q),
    "command while busy changed the sequencer")
  `SMSQ_ASSERT_NEXT(a_idle_cmd_starts,
    adv && (in_mode_q == MODE_STRAIGHT || in_mode_q == MODE_ROTATE) && phase_q == PH_IDLE,
    phase_q == PH_SETTLE_ON && tick_q == '0,
    "command while idle did not start a move")
  `SMSQ_ASSERT_NOW(a_stall_only_when_full,
    !s_axis_tready,
    in_valid_q && out_valid_q && !m_axis_tready,
    "input stalled with room in the pipeline")
  `SMSQ_ASSERT_NOW(a_step_needs_driver,
    out_valid_q && result_q.step_level,
    !result_q.driver_off && result_q.busy_res,
    "step pulse shown with the driver off")

endmodule

// ===== dv/stepper_move_sequencer_test.sv =====
// self-checking testbench for the stepper move sequencer: status beats vs a local sequencer model
module stepper_move_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smsq_pkg::*;

  // mode value with no defined command
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 100;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SETTLE_ON,
    SEQ_HIGH,
    SEQ_LOW,
    SEQ_SETTLE_OFF
  } seq_phase_e;

  typedef struct {
    logic [1:0]          mode;
    logic [AMOUNT_W-1:0] amount;
  } cmd_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [SCALE_W-1:0]    cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [AMOUNT_W-1:0]   s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // sequencer model state and its copy of the registers
  seq_phase_e            seq_phase = SEQ_IDLE;
  logic [15:0]           steps_left = '0;
  logic [TICK_W-1:0]     seq_ticks = '0;
  logic                  left_fwd = 1'b0;
  logic                  right_fwd = 1'b0;
  logic [TOTAL_W-1:0]    last_steps = '0;
  logic [SCALE_W-1:0]    mm_scale = SCALE_RST;
  logic [SCALE_W-1:0]    deg_scale = SCALE_RST;
  logic [SETTLE_W-1:0]   settle_len = SETTLE_RST;
  logic [PULSE_W-1:0]    high_len = PULSE_RST;
  logic [PULSE_W-1:0]    low_len = PULSE_RST;

  cmd_beat_t             cmd_beats[$];
  result_t               status_expected[$];
  int                    beats_queued = 0;
  int                    beats_accepted = 0;
  int                    fail_count = 0;
  int unsigned           cycle_count = 0;
  int                    src_gap = 0;
  int                    sink_stall = 0;
  int                    rx_hold_left = 0;
  logic                  rx_hold_arm = 1'b0;
  logic                  rx_hold_used = 1'b0;
  logic                  idle_on = 1'b0;

  stepper_move_sequencer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // magnitude times Q8.16 scale, rounded half up, saturated to the count range
  function automatic logic [TOTAL_W-1:0] scaled_steps(logic [16:0] mag, logic [SCALE_W-1:0] scale);
    logic [63:0] prod;
    prod = (64'(mag) * 64'(scale) + 64'h8000) >> 16;
    return (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
  endfunction

  // advance the sequencer model by one input beat and return the status it shows
  function automatic result_t predict_status(logic [1:0] mode, logic [AMOUNT_W-1:0] amount);
    result_t     res;
    logic        rej;
    logic        neg;
    logic [16:0] mag;
    logic [15:0] len;
    rej = 1'b0;
    if (mode == MODE_STRAIGHT || mode == MODE_ROTATE) begin
      if (seq_phase != SEQ_IDLE) begin
        rej = 1'b1;
      end else begin
        neg = amount[AMOUNT_W-1];
        mag = neg ? (17'h10000 - {1'b0, amount}) : {1'b0, amount};
        // zero amount keeps the old directions
        if (amount != '0) begin
          left_fwd = !neg;
          right_fwd = (mode == MODE_STRAIGHT) ? !neg : neg;
        end
        last_steps = scaled_steps(mag, (mode == MODE_STRAIGHT) ? mm_scale : deg_scale);
        steps_left = last_steps;
        seq_ticks = '0;
        seq_phase = SEQ_SETTLE_ON;
      end
    end else if (mode == MODE_TICK && seq_phase != SEQ_IDLE) begin
      case (seq_phase)
        SEQ_HIGH: len = {8'd0, high_len};
        SEQ_LOW:  len = {8'd0, low_len};
        default:  len = settle_len;
      endcase
      seq_ticks = seq_ticks + 16'd1;
      // a phase ends once its count reaches the length, zero acts as one
      if (seq_ticks >= len) begin
        seq_ticks = '0;
        case (seq_phase)
          SEQ_SETTLE_ON, SEQ_LOW: begin
            if (steps_left != '0) begin
              steps_left = steps_left - 16'd1;
              seq_phase = SEQ_HIGH;
            end else begin
              seq_phase = SEQ_SETTLE_OFF;
            end
          end
          SEQ_HIGH: seq_phase = SEQ_LOW;
          default:  seq_phase = SEQ_IDLE;
        endcase
      end
    end
    res = '0;
    res.driver_off = (seq_phase == SEQ_IDLE);
    res.step_level = (seq_phase == SEQ_HIGH);
    res.dir_left = left_fwd;
    res.dir_right = right_fwd;
    res.busy_res = (seq_phase != SEQ_IDLE);
    res.rejected = rej;
    res.step_total = last_steps;
    return res;
  endfunction

  // idle length: mostly short, a few long
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 60)) : int'($urandom_range(1, 3));
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 3))
      0:       return SCALE_W'($urandom_range(0, 80));
      1:       return SCALE_W'($urandom_range(0, 24'h03FFFF));
      2:       return SCALE_W'($urandom);
      default: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    endcase
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // compare one status beat with the oldest expected one
  task automatic check_status(result_t got);
    result_t want;
    if (status_expected.size() == 0) begin
      note_failure($sformatf("status beat %h with none expected", got));
    end else begin
      want = status_expected.pop_front();
      if (got.driver_off !== want.driver_off || got.step_level !== want.step_level ||
          got.dir_left !== want.dir_left || got.dir_right !== want.dir_right ||
          got.busy_res !== want.busy_res || got.rejected !== want.rejected ||
          got.step_total !== want.step_total || got.pad !== want.pad) begin
        note_failure($sformatf(
          "status mismatch off/step/dl/dr/busy/rej/total/pad exp %b%b%b%b%b%b %0d %b got %b%b%b%b%b%b %0d %b",
          want.driver_off, want.step_level, want.dir_left, want.dir_right, want.busy_res,
          want.rejected, want.step_total, want.pad, got.driver_off, got.step_level,
          got.dir_left, got.dir_right, got.busy_res, got.rejected, got.step_total, got.pad));
      end
    end
  endtask

  task automatic send_beat(logic [1:0] mode, logic [AMOUNT_W-1:0] amount);
    cmd_beat_t b;
    b.mode = mode;
    b.amount = amount;
    cmd_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic wait_sent();
    while (beats_accepted != beats_queued) @(posedge clk_i);
  endtask

  // one register write; the model takes the value at the handshake
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_STRAIGHT_SCALE: mm_scale = data;
      REG_ROTATE_SCALE:   deg_scale = data;
      REG_SETTLE_TICKS:   settle_len = data[SETTLE_W-1:0];
      REG_HIGH_TICKS:     high_len = data[PULSE_W-1:0];
      REG_LOW_TICKS:      low_len = data[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  // tick the sequencer back to idle and let every status beat drain
  task automatic quiesce();
    wait_sent();
    while (seq_phase != SEQ_IDLE) begin
      for (int i = 0; i < 16; i++) send_beat(MODE_TICK, AMOUNT_W'($urandom));
      wait_sent();
    end
    while (status_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // input driver: model update on each accepted beat, then next beat or gap
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_beat_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_expected.push_back(predict_status(s_axis_tuser, s_axis_tdata));
        beats_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (cmd_beats.size() != 0) begin
          nxt = cmd_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.amount;
          s_axis_tuser <= nxt.mode;
          src_gap <= (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, used once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left <= 0;
      rx_hold_used <= 1'b0;
    end else if (rx_hold_arm && !rx_hold_used) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_used <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result monitor with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_status(result_t'(m_axis_tdata));
      if (rx_hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (sink_stall != 0) begin
        m_axis_tready <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        sink_stall <= gap_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int                 made;
    int                 cap;
    int                 mag;
    int                 est;
    int                 n;
    logic [1:0]         mode;
    logic [SCALE_W-1:0] scl;
    logic [AMOUNT_W-1:0] amt;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: unused mode, idle tick, one step, commands while busy
    send_beat(MODE_UNUSED, 16'hFFFF);
    send_beat(MODE_TICK, 16'h0000);
    send_beat(MODE_STRAIGHT, 16'd1);
    send_beat(MODE_STRAIGHT, -16'sd5);
    send_beat(MODE_ROTATE, 16'd3);
    send_beat(MODE_TICK, 16'h7FFF);
    send_beat(MODE_UNUSED, 16'h0000);
    quiesce();

    // zero and full scales, zero settle, index beyond the list
    write_reg(REG_STRAIGHT_SCALE, 24'hFFFFFF);
    write_reg(REG_ROTATE_SCALE, 24'h000000);
    write_reg(REG_SETTLE_TICKS, 24'hAB0000);
    write_reg(REG_HIGH_TICKS, 24'h000001);
    write_reg(REG_LOW_TICKS, 24'hFFFF01);
    write_reg(8'hFF, 24'h5A5A5A);
    // rotate left with zero scale: no pulses
    send_beat(MODE_ROTATE, 16'h8000);
    quiesce();
    // zero amount keeps directions
    send_beat(MODE_STRAIGHT, 16'h0000);
    quiesce();

    // rounding just at and just below one half
    write_reg(REG_ROTATE_SCALE, 24'h008000);
    write_reg(REG_STRAIGHT_SCALE, 24'h007FFF);
    send_beat(MODE_ROTATE, 16'd1);
    quiesce();
    send_beat(MODE_STRAIGHT, 16'hFFFF);
    quiesce();

    // longest pulse lengths
    write_reg(REG_SETTLE_TICKS, 24'h000003);
    write_reg(REG_HIGH_TICKS, 24'h0000FF);
    write_reg(REG_LOW_TICKS, 24'h0000FF);
    write_reg(REG_STRAIGHT_SCALE, SCALE_RST);
    send_beat(MODE_STRAIGHT, -16'sd1);
    quiesce();

    // random phases of command and tick sequences
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      idle_on <= (k == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_reg(REG_STRAIGHT_SCALE, rand_scale());
      write_reg(REG_ROTATE_SCALE, rand_scale());
      write_reg(REG_SETTLE_TICKS, {8'($urandom), 16'($urandom_range(0, 6))});
      write_reg(REG_HIGH_TICKS, {16'($urandom), 8'($urandom_range(1, 5))});
      write_reg(REG_LOW_TICKS, {16'($urandom), 8'($urandom_range(1, 5))});
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_LOW_TICKS) + 1, 255)), SCALE_W'($urandom));
      // receiver holds off while the sender keeps going
      if (k == 2) rx_hold_arm <= 1'b1;
      made = 0;
      while (made < BEATS_PER_PHASE) begin
        mode = $urandom_range(0, 1) ? MODE_ROTATE : MODE_STRAIGHT;
        scl = (mode == MODE_STRAIGHT) ? mm_scale : deg_scale;
        // keep the step count small
        cap = (scl == '0) ? 32768 : int'((64'd8 << 16) / scl);
        if (cap > 32768) cap = 32768;
        mag = $urandom_range(0, cap);
        if ($urandom_range(0, 15) == 0) mag = 0;
        if ($urandom_range(0, 1) && mag != 0) amt = AMOUNT_W'(-mag);
        else amt = AMOUNT_W'((mag > 32767) ? 32767 : mag);
        if ($urandom_range(0, 7) == 0) begin
          send_beat(MODE_UNUSED, AMOUNT_W'($urandom));
          made++;
        end
        send_beat(mode, amt);
        made++;
        // a second command lands while busy
        if ($urandom_range(0, 5) == 0) begin
          send_beat($urandom_range(0, 1) ? MODE_ROTATE : MODE_STRAIGHT, AMOUNT_W'($urandom));
          made++;
        end
        est = 2 * ((settle_len == '0) ? 1 : int'(settle_len)) +
              int'(scaled_steps(17'(mag), scl)) * (int'(high_len) + int'(low_len));
        n = $urandom_range(0, est + est / 4 + 2);
        for (int i = 0; i < n; i++) send_beat(MODE_TICK, AMOUNT_W'($urandom));
        made += n;
      end
      quiesce();
    end

    idle_on <= 1'b0;
    quiesce();

    // saturated step count, left running at the end
    write_reg(REG_STRAIGHT_SCALE, 24'hFFFFFF);
    send_beat(MODE_STRAIGHT, 16'h7FFF);
    for (int i = 0; i < 8; i++) send_beat(MODE_TICK, AMOUNT_W'($urandom));
    send_beat(MODE_ROTATE, 16'd1);
    wait_sent();
    while (status_expected.size() != 0) @(posedge clk_i);

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/smsq_pkg.sv
hdl/smsq_scale.sv
hdl/stepper_move_sequencer.sv
dv/stepper_move_sequencer_test.sv
